[src/vfyr_pkg.sv]
// Package: shared types and constants of the vertical filter and YUV to RGB block.
`timescale 1ns / 1ps

package vfyr_pkg;

    // Field widths
    localparam int SAMPLE_W    = 16;
    localparam int ACC_W       = 32;
    localparam int PIXEL_W     = 24;
    localparam int CFG_FMT_W   = 2;
    localparam int CFG_TAP_W   = 5;
    localparam int CFG_PAIRS_W = 11;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 2;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_FORMAT   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LUMA_TAPS      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHROMA_TAPS    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAIRS_PER_LINE = 2'd3;

    // Output formats
    localparam logic [CFG_FMT_W-1:0] FMT_BGR32  = 2'd0;
    localparam logic [CFG_FMT_W-1:0] FMT_BGR24  = 2'd1;
    localparam logic [CFG_FMT_W-1:0] FMT_RGB565 = 2'd2;
    localparam logic [CFG_FMT_W-1:0] FMT_RGB555 = 2'd3;

    // Depth of the queue between the filter and the color converter
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // Configuration registers as seen by both halves
    typedef struct packed {
        logic [CFG_FMT_W-1:0]   pixel_format;
        logic [CFG_TAP_W-1:0]   luma_taps;
        logic [CFG_TAP_W-1:0]   chroma_taps;
        logic [CFG_PAIRS_W-1:0] pairs_per_line;
    } cfg_t;

    // Filtered sums of one finished pair
    typedef struct packed {
        logic [ACC_W-1:0] luma_first;
        logic [ACC_W-1:0] luma_second;
        logic [ACC_W-1:0] u_sum;
        logic [ACC_W-1:0] v_sum;
        logic             line_end;
    } pair_sums_t;

endpackage

[src/vfyr_front.sv]
// Front end: takes tap beats, runs the vertical multiply-accumulate, hands off finished pairs.
`timescale 1ns / 1ps

module vfyr_front
    import vfyr_pkg::*;
#(
    parameter int MAX_TAPS  = 16,
    parameter int MAX_PAIRS = 1024
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cfg_t                       cfg,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [SAMPLE_W-1:0] luma_first,
    input  logic signed [SAMPLE_W-1:0] luma_second,
    input  logic signed [SAMPLE_W-1:0] chroma_u,
    input  logic signed [SAMPLE_W-1:0] chroma_v,
    input  logic signed [SAMPLE_W-1:0] luma_weight,
    input  logic signed [SAMPLE_W-1:0] chroma_weight,
    input  logic                       q_full,
    output logic                       q_push,
    output pair_sums_t                 q_data
);

    localparam int TAP_W   = $clog2(MAX_TAPS + 1);
    localparam int TCMP_W  = ((TAP_W > CFG_TAP_W) ? TAP_W : CFG_TAP_W) + 1;
    localparam int PAIR_W  = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
    localparam int PCMP_W  = ((PAIR_W + 1 > CFG_PAIRS_W) ? PAIR_W + 1 : CFG_PAIRS_W) + 1;
    localparam logic [TCMP_W-1:0] TAP_LIMIT  = TCMP_W'(MAX_TAPS);
    localparam logic [PCMP_W-1:0] PAIR_LIMIT = PCMP_W'(MAX_PAIRS);

    logic [TAP_W-1:0]  tap_index_reg, tap_index_next;
    logic [PAIR_W-1:0] pair_index_reg, pair_index_next;
    logic [ACC_W-1:0]  luma_acc_first_reg, luma_acc_first_next;
    logic [ACC_W-1:0]  luma_acc_second_reg, luma_acc_second_next;
    logic [ACC_W-1:0]  u_acc_reg, u_acc_next;
    logic [ACC_W-1:0]  v_acc_reg, v_acc_next;

    logic [TCMP_W-1:0] luma_eff, chroma_eff, total, tap_ext;
    logic [PCMP_W-1:0] ppl_eff, pair_ext;
    logic              luma_on, chroma_on, closing, last_pair, accept;
    logic signed [ACC_W-1:0] prod_lf, prod_ls, prod_u, prod_v;
    logic [ACC_W-1:0]  sum_lf, sum_ls, sum_u, sum_v;

    // Effective tap counts and line length
    always_comb
    begin
        luma_eff   = (TCMP_W'(cfg.luma_taps) > TAP_LIMIT) ? TAP_LIMIT : TCMP_W'(cfg.luma_taps);
        chroma_eff = (TCMP_W'(cfg.chroma_taps) > TAP_LIMIT) ? TAP_LIMIT
                                                            : TCMP_W'(cfg.chroma_taps);
        total      = (luma_eff > chroma_eff) ? luma_eff : chroma_eff;
        if (total == '0)
        begin
            total = TCMP_W'(1);
        end
        ppl_eff = PCMP_W'(cfg.pairs_per_line);
        if (ppl_eff == '0)
        begin
            ppl_eff = PCMP_W'(1);
        end
        if (ppl_eff > PAIR_LIMIT)
        begin
            ppl_eff = PAIR_LIMIT;
        end
    end

    assign tap_ext   = TCMP_W'(tap_index_reg);
    assign pair_ext  = PCMP_W'(pair_index_reg);
    assign luma_on   = tap_ext < luma_eff;
    assign chroma_on = tap_ext < chroma_eff;
    assign closing   = (tap_ext + TCMP_W'(1)) >= total;
    assign last_pair = (pair_ext + PCMP_W'(1)) >= ppl_eff;

    // A closing beat needs a free queue slot
    assign in_ready = !closing || !q_full;
    assign accept   = in_valid && in_ready;

    // Four multiply-accumulates, wrapping at 32 bits
    assign prod_lf = luma_first * luma_weight;
    assign prod_ls = luma_second * luma_weight;
    assign prod_u  = chroma_u * chroma_weight;
    assign prod_v  = chroma_v * chroma_weight;

    assign sum_lf = luma_on   ? luma_acc_first_reg + ACC_W'(prod_lf)  : luma_acc_first_reg;
    assign sum_ls = luma_on   ? luma_acc_second_reg + ACC_W'(prod_ls) : luma_acc_second_reg;
    assign sum_u  = chroma_on ? u_acc_reg + ACC_W'(prod_u)            : u_acc_reg;
    assign sum_v  = chroma_on ? v_acc_reg + ACC_W'(prod_v)            : v_acc_reg;

    // Hand-off to the queue
    assign q_push              = accept && closing;
    assign q_data.luma_first   = sum_lf;
    assign q_data.luma_second  = sum_ls;
    assign q_data.u_sum        = sum_u;
    assign q_data.v_sum        = sum_v;
    assign q_data.line_end     = last_pair;

    // Tap and line position
    always_comb
    begin
        tap_index_next       = tap_index_reg;
        pair_index_next      = pair_index_reg;
        luma_acc_first_next  = luma_acc_first_reg;
        luma_acc_second_next = luma_acc_second_reg;
        u_acc_next           = u_acc_reg;
        v_acc_next           = v_acc_reg;
        if (accept)
        begin
            if (closing)
            begin
                tap_index_next       = '0;
                pair_index_next      = last_pair ? '0 : pair_index_reg + PAIR_W'(1);
                luma_acc_first_next  = '0;
                luma_acc_second_next = '0;
                u_acc_next           = '0;
                v_acc_next           = '0;
            end
            else
            begin
                tap_index_next       = tap_index_reg + TAP_W'(1);
                luma_acc_first_next  = sum_lf;
                luma_acc_second_next = sum_ls;
                u_acc_next           = sum_u;
                v_acc_next           = sum_v;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_index_reg       <= '0;
            pair_index_reg      <= '0;
            luma_acc_first_reg  <= '0;
            luma_acc_second_reg <= '0;
            u_acc_reg           <= '0;
            v_acc_reg           <= '0;
        end
        else
        begin
            tap_index_reg       <= tap_index_next;
            pair_index_reg      <= pair_index_next;
            luma_acc_first_reg  <= luma_acc_first_next;
            luma_acc_second_reg <= luma_acc_second_next;
            u_acc_reg           <= u_acc_next;
            v_acc_reg           <= v_acc_next;
        end
    end

endmodule

[src/vfyr_queue.sv]
// Two-entry queue of finished pair sums between the filter and the color converter.
`timescale 1ns / 1ps

module vfyr_queue
    import vfyr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  pair_sums_t push_data,
    input  logic       pop,
    output logic       full,
    output logic       not_empty,
    output pair_sums_t head
);

    pair_sums_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    assign full      = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign head      = entry_reg[rd_ptr_reg];

    // Pointer and fill count
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[src/vfyr_back.sv]
// Back end: normalizes pair sums, runs the BT.601 conversion and packs two pixels.
`timescale 1ns / 1ps

module vfyr_back
    import vfyr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               q_not_empty,
    input  pair_sums_t         q_head,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [PIXEL_W-1:0] pixel_word_first,
    output logic [PIXEL_W-1:0] pixel_word_second,
    output logic               line_end
);

    localparam int CONV_W = 26;
    localparam logic signed [CONV_W-1:0] COEF_Y   = 26'sh2568;
    localparam logic signed [CONV_W-1:0] COEF_RV  = 26'sh3343;
    localparam logic signed [CONV_W-1:0] COEF_GU  = 26'sh0c92;
    localparam logic signed [CONV_W-1:0] COEF_GV  = 26'sh1a1e;
    localparam logic signed [CONV_W-1:0] COEF_BU  = 26'sh40cf;
    localparam logic signed [CONV_W-1:0] Y_OFFSET = 26'sd2097152;

    // Sum >> 19, clamped to 0..255
    function automatic logic [7:0] norm8(input logic [ACC_W-1:0] acc);
        logic signed [12:0] v;
        v = $signed(acc[ACC_W-1:19]);
        if (v < 0)
        begin
            return 8'd0;
        end
        else if (v > 13'sd255)
        begin
            return 8'd255;
        end
        return v[7:0];
    endfunction

    // (sum >> 13) - 256, clipped to 0..255
    function automatic logic [7:0] chan(input logic signed [CONV_W-1:0] s);
        logic signed [12:0] t;
        t = $signed(s[CONV_W-1:13]) - 13'sd256;
        if (t < 0)
        begin
            return 8'd0;
        end
        else if (t > 13'sd255)
        begin
            return 8'd255;
        end
        return t[7:0];
    endfunction

    function automatic logic [PIXEL_W-1:0] pack(input logic [CFG_FMT_W-1:0] fmt,
                                                input logic [7:0] b,
                                                input logic [7:0] g,
                                                input logic [7:0] r);
        logic [PIXEL_W-1:0] w;
        case (fmt)
            FMT_RGB565: w = {8'd0, r[7:3], g[7:2], b[7:3]};
            FMT_RGB555: w = {9'd0, r[7:3], g[7:3], b[7:3]};
            default:    w = {r, g, b};
        endcase
        return w;
    endfunction

    logic advance;

    // Stage 1: normalized, offset samples
    logic                    s1_valid_reg, s1_valid_next;
    logic signed [8:0]       s1_y1_reg, s1_y2_reg, s1_cu_reg, s1_cv_reg;
    logic                    s1_line_end_reg;

    // Stage 2: scaled luma and chroma terms
    logic                    s2_valid_reg, s2_valid_next;
    logic signed [CONV_W-1:0] s2_y1_reg, s2_y2_reg, s2_cb_reg, s2_cg_reg, s2_cr_reg;
    logic                    s2_line_end_reg;

    // Output register
    logic                    out_valid_reg, out_valid_next;
    logic [PIXEL_W-1:0]      out_first_reg, out_first_next;
    logic [PIXEL_W-1:0]      out_second_reg, out_second_next;
    logic                    out_line_end_reg;

    // Whole pipeline moves unless a result is waiting
    assign advance = !out_valid_reg || out_ready;
    assign q_pop   = advance && q_not_empty;

    assign s1_valid_next  = advance ? q_not_empty : s1_valid_reg;
    assign s2_valid_next  = advance ? s1_valid_reg : s2_valid_reg;
    assign out_valid_next = advance ? s2_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Final channel sums and packing
    always_comb
    begin
        out_first_next  = pack(cfg.pixel_format, chan(s2_y1_reg + s2_cb_reg),
                               chan(s2_y1_reg + s2_cg_reg), chan(s2_y1_reg + s2_cr_reg));
        out_second_next = pack(cfg.pixel_format, chan(s2_y2_reg + s2_cb_reg),
                               chan(s2_y2_reg + s2_cg_reg), chan(s2_y2_reg + s2_cr_reg));
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_y1_reg        <= $signed({1'b0, norm8(q_head.luma_first)}) - 9'sd16;
            s1_y2_reg        <= $signed({1'b0, norm8(q_head.luma_second)}) - 9'sd16;
            s1_cu_reg        <= $signed({1'b0, norm8(q_head.u_sum)}) - 9'sd128;
            s1_cv_reg        <= $signed({1'b0, norm8(q_head.v_sum)}) - 9'sd128;
            s1_line_end_reg  <= q_head.line_end;

            s2_y1_reg        <= COEF_Y * CONV_W'(s1_y1_reg) + Y_OFFSET;
            s2_y2_reg        <= COEF_Y * CONV_W'(s1_y2_reg) + Y_OFFSET;
            s2_cb_reg        <= COEF_BU * CONV_W'(s1_cu_reg);
            s2_cg_reg        <= -(COEF_GV * CONV_W'(s1_cv_reg)) - (COEF_GU * CONV_W'(s1_cu_reg));
            s2_cr_reg        <= COEF_RV * CONV_W'(s1_cv_reg);
            s2_line_end_reg  <= s1_line_end_reg;

            out_first_reg    <= out_first_next;
            out_second_reg   <= out_second_next;
            out_line_end_reg <= s2_line_end_reg;
        end
    end

    assign out_valid         = out_valid_reg;
    assign pixel_word_first  = out_first_reg;
    assign pixel_word_second = out_second_reg;
    assign line_end          = out_line_end_reg;

endmodule

[src/vertical_filter_yuv_to_rgb_top.sv]
// Top level: configuration registers, filter front end, pair queue and color converter.
`timescale 1ns / 1ps

// Vertical FIR plus BT.601 YUV to RGB for pixel pairs. Each input beat is one vertical
// tap of a pair; the front end accepts one beat per clock and multiply-accumulates it
// into four 32-bit sums. The beat numbered max(luma_taps, chroma_taps), each capped at
// MAX_TAPS, closes the pair and drops its sums into a two-entry queue; that beat waits
// only if the queue is full. The converter takes one pair per clock from the queue
// unless out_ready holds its output, through a three-register pipeline (normalize,
// scale, clip and pack). N taps cost N input beats unless a held output fills the queue.
// Configuration writes take effect on the next clock; change them only while idle.

module vertical_filter_yuv_to_rgb_top
    import vfyr_pkg::*;
#(
    parameter int MAX_TAPS  = 16,
    parameter int MAX_PAIRS = 1024
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic [CFG_INDEX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [SAMPLE_W-1:0] luma_first,
    input  logic signed [SAMPLE_W-1:0] luma_second,
    input  logic signed [SAMPLE_W-1:0] chroma_u,
    input  logic signed [SAMPLE_W-1:0] chroma_v,
    input  logic signed [SAMPLE_W-1:0] luma_weight,
    input  logic signed [SAMPLE_W-1:0] chroma_weight,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [PIXEL_W-1:0]         pixel_word_first,
    output logic [PIXEL_W-1:0]         pixel_word_second,
    output logic                       line_end
);

    cfg_t       cfg_reg, cfg_next;
    logic       q_full, q_push, q_pop, q_not_empty;
    pair_sums_t q_in, q_head;

    // Configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_PIXEL_FORMAT:   cfg_next.pixel_format   = cfg_data[CFG_FMT_W-1:0];
                CFG_LUMA_TAPS:      cfg_next.luma_taps      = cfg_data[CFG_TAP_W-1:0];
                CFG_CHROMA_TAPS:    cfg_next.chroma_taps    = cfg_data[CFG_TAP_W-1:0];
                CFG_PAIRS_PER_LINE: cfg_next.pairs_per_line = cfg_data[CFG_PAIRS_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pixel_format   <= FMT_BGR32;
            cfg_reg.luma_taps      <= CFG_TAP_W'(1);
            cfg_reg.chroma_taps    <= CFG_TAP_W'(1);
            cfg_reg.pairs_per_line <= CFG_PAIRS_W'(1);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    vfyr_front #(
        .MAX_TAPS  (MAX_TAPS),
        .MAX_PAIRS (MAX_PAIRS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .luma_first    (luma_first),
        .luma_second   (luma_second),
        .chroma_u      (chroma_u),
        .chroma_v      (chroma_v),
        .luma_weight   (luma_weight),
        .chroma_weight (chroma_weight),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_data        (q_in)
    );

    vfyr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    vfyr_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg               (cfg_reg),
        .q_not_empty       (q_not_empty),
        .q_head            (q_head),
        .q_pop             (q_pop),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .pixel_word_first  (pixel_word_first),
        .pixel_word_second (pixel_word_second),
        .line_end          (line_end)
    );

endmodule
